// ===== src/assert_macros.svh =====
// assertion helpers used by the converter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion lbl failed");

// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion lbl failed");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== src/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned CompW   = 8;
  localparam int unsigned HueW    = 15;
  // hue numerator 7680*|diff| + chroma, divided by 2*chroma
  localparam int unsigned NumHW   = 21;
  localparam int unsigned DenHW   = 9;
  localparam int unsigned QHW     = 12;
  // saturation numerator 510*chroma + max, divided by 2*max
  localparam int unsigned NumSW   = 17;
  localparam int unsigned DenSW   = 9;
  localparam int unsigned QSW     = 8;
  localparam int unsigned HueSW   = 17;

  localparam int unsigned HueSector    = 3840;
  localparam int unsigned HueNumScale  = 2 * HueSector;
  localparam int unsigned SatNumScale  = 2 * 255;
  localparam int unsigned HueGreenBase = 7680;
  localparam int unsigned HueBlueBase  = 15360;
  localparam int unsigned HueFullTurn  = 23040;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // after max/min search
  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              grey;
    logic [CompW-1:0]  mx;
    logic [CompW-1:0]  chroma;
    logic [CompW-1:0]  mag;
    logic [CompW-1:0]  alpha;
  } front_t;

  // one stage of the two long divisions
  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              grey;
    logic [CompW-1:0]  mx;
    logic [CompW-1:0]  alpha;
    logic [NumHW-1:0]  rem_h;
    logic [DenHW-1:0]  den_h;
    logic [QHW-1:0]    q_h;
    logic [NumSW-1:0]  rem_s;
    logic [DenSW-1:0]  den_s;
    logic [QSW-1:0]    q_s;
  } div_t;

endpackage

`default_nettype wire

// ===== src/rgb_to_hsv_converter_core.sv =====
`default_nettype none
// channel  | dir | tdata (low bit up)                          | tuser
// s_axis   | in  | red 8, green 8, blue 8, alpha 8 (32 bits)   | -
// m_axis   | out | hue 15, saturation 8, value 8, alpha 8, pad | hue_missing
//
// one word per clock sustained while m_axis_tready stays high
// the division stages form two restoring dividers, one quotient bit per stage (12 for hue)
// reset clears only the stage valid bits; payload registers are not reset
// every stage holds its word when the next one is full and stalled, and empty
// stages are filled up, so s_axis_tready drops only when the whole pipe is full
`include "assert_macros.svh"

module rgb_to_hsv_converter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // hue, saturation, value, alpha, zero pad
  output logic             m_axis_tuser    // hue_missing
);

  import rgbhsv_pkg::*;

  localparam int unsigned NDiv = QHW;

  logic [CompW-1:0] red, green, blue, alpha_in;
  logic [CompW-1:0] mx_rg, mn_rg, mx, mn;
  logic signed [CompW:0] diff;

  front_t front_d, front_q;
  logic   front_vld_q;
  logic   front_adv;

  div_t   div_q   [NDiv+1];
  div_t   div_d   [NDiv+1];
  logic   div_vld_q [NDiv+1];
  logic   div_adv   [NDiv+1];

  logic                  out_adv;
  logic                  out_vld_q;
  logic [HueW-1:0]       hue_d, hue_q;
  logic                  miss_q;
  logic [CompW-1:0]      sat_d, sat_q;
  logic [CompW-1:0]      val_q, alpha_q;
  logic signed [HueSW-1:0] hue_base, hue_off, hue_raw;

  // stage advance chain, from the output back to the input
  assign out_adv = !out_vld_q || m_axis_tready;
  assign div_adv[NDiv] = !div_vld_q[NDiv] || out_adv;
  for (genvar k = 0; k < NDiv; k++) begin : g_adv
    assign div_adv[k] = !div_vld_q[k] || div_adv[k+1];
  end
  assign front_adv     = !front_vld_q || div_adv[0];
  assign s_axis_tready = front_adv;

  // max, min, sector and signed difference
  assign red      = s_axis_tdata[7:0];
  assign green    = s_axis_tdata[15:8];
  assign blue     = s_axis_tdata[23:16];
  assign alpha_in = s_axis_tdata[31:24];

  always_comb begin
    mx_rg = (red > green) ? red : green;
    mn_rg = (red < green) ? red : green;
    mx    = (blue > mx_rg) ? blue : mx_rg;
    mn    = (blue < mn_rg) ? blue : mn_rg;
    // red wins ties, then green
    if (mx == red) begin
      front_d.sector = SecRed;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx == green) begin
      front_d.sector = SecGreen;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      front_d.sector = SecBlue;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    front_d.neg    = diff[CompW];
    front_d.mag    = diff[CompW] ? CompW'(-diff) : diff[CompW-1:0];
    front_d.mx     = mx;
    front_d.chroma = mx - mn;
    front_d.grey   = (mx == mn);
    front_d.alpha  = alpha_in;
  end

  // numerators carry the half divisor so a floor quotient rounds to nearest
  always_comb begin
    div_d[0].sector = front_q.sector;
    div_d[0].neg    = front_q.neg;
    div_d[0].grey   = front_q.grey;
    div_d[0].mx     = front_q.mx;
    div_d[0].alpha  = front_q.alpha;
    div_d[0].rem_h  = NumHW'(front_q.mag) * NumHW'(HueNumScale) + NumHW'(front_q.chroma);
    div_d[0].den_h  = {front_q.chroma, 1'b0};
    div_d[0].q_h    = '0;
    div_d[0].rem_s  = NumSW'(front_q.chroma) * NumSW'(SatNumScale) + NumSW'(front_q.mx);
    div_d[0].den_s  = {front_q.mx, 1'b0};
    div_d[0].q_s    = '0;
  end

  // restoring division, one hue quotient bit per stage; saturation bits only in stages below bit QSW
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    localparam int unsigned HBit = NDiv - 1 - k;
    logic [NumHW-1:0] trial_h;
    assign trial_h = NumHW'(div_q[k].den_h) << HBit;

    if (HBit < QSW) begin : g_sat
      logic [NumSW-1:0] trial_s;
      assign trial_s = NumSW'(div_q[k].den_s) << HBit;
      always_comb begin
        div_d[k+1] = div_q[k];
        if (div_q[k].rem_h >= trial_h) begin
          div_d[k+1].rem_h    = div_q[k].rem_h - trial_h;
          div_d[k+1].q_h[HBit] = 1'b1;
        end
        if (div_q[k].rem_s >= trial_s) begin
          div_d[k+1].rem_s    = div_q[k].rem_s - trial_s;
          div_d[k+1].q_s[HBit] = 1'b1;
        end
      end
    end else begin : g_hue_only
      always_comb begin
        div_d[k+1] = div_q[k];
        if (div_q[k].rem_h >= trial_h) begin
          div_d[k+1].rem_h    = div_q[k].rem_h - trial_h;
          div_d[k+1].q_h[HBit] = 1'b1;
        end
      end
    end
  end

  // sector offset, sign and wrap into one turn
  always_comb begin
    case (div_q[NDiv].sector)
      SecRed:   hue_base = '0;
      SecGreen: hue_base = HueSW'(HueGreenBase);
      SecBlue:  hue_base = HueSW'(HueBlueBase);
      default:  hue_base = '0;
    endcase
    hue_off = $signed({{(HueSW-QHW){1'b0}}, div_q[NDiv].q_h});
    hue_raw = div_q[NDiv].neg ? (hue_base - hue_off) : (hue_base + hue_off);
    if (hue_raw < 0) begin
      hue_raw = hue_raw + $signed(HueSW'(HueFullTurn));
    end else if (hue_raw >= $signed(HueSW'(HueFullTurn))) begin
      hue_raw = hue_raw - $signed(HueSW'(HueFullTurn));
    end
    if (div_q[NDiv].grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hue_raw[HueW-1:0];
      sat_d = div_q[NDiv].q_s;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
      for (int k = 0; k <= NDiv; k++) begin
        div_vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      if (front_adv) begin
        front_vld_q <= s_axis_tvalid;
      end
      if (div_adv[0]) begin
        div_vld_q[0] <= front_vld_q;
      end
      for (int k = 0; k < NDiv; k++) begin
        if (div_adv[k+1]) begin
          div_vld_q[k+1] <= div_vld_q[k];
        end
      end
      if (out_adv) begin
        out_vld_q <= div_vld_q[NDiv];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      front_q <= front_d;
    end
    for (int k = 0; k <= NDiv; k++) begin
      if (div_adv[k]) begin
        div_q[k] <= div_d[k];
      end
    end
    if (out_adv) begin
      hue_q   <= hue_d;
      miss_q  <= div_q[NDiv].grey;
      sat_q   <= sat_d;
      val_q   <= div_q[NDiv].mx;
      alpha_q <= div_q[NDiv].alpha;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, alpha_q, val_q, sat_q, hue_q};
  assign m_axis_tuser  = miss_q;

  `ASSERT_PROP(a_grey_zero, clk_i, rst_ni, (out_vld_q && miss_q) |-> (hue_q == '0 && sat_q == '0))
  `ASSERT_NEVER(a_hue_range, clk_i, rst_ni, out_vld_q && (hue_q >= HueW'(HueFullTurn)))
  `ASSERT_PROP(a_colour_nonzero, clk_i, rst_ni, (out_vld_q && !miss_q) |-> (val_q != '0 && sat_q != '0))
  `ASSERT_PROP(a_full_stall, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))

endmodule

`default_nettype wire

// ===== tb/sv/hsv_pixel_checker.sv =====
`timescale 1ns / 100ps

module hsv_pixel_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [31:0] s_tdata_i,    // red, green, blue, alpha
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [39:0] m_tdata_i,    // hue, saturation, value, alpha, zero pad
  input  wire logic        m_tuser_i,    // hue_missing
  output int               mismatches_o,
  output int               pending_o
);

  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [14:0] hue;
    logic        missing;
    logic [7:0]  sat;
    logic [7:0]  value;
    logic [7:0]  alpha;
    logic        pad;
  } hsv_word_t;

  hsv_word_t hsv_q[$];
  int        fails = 0;

  function automatic hsv_word_t rgb_to_hsv(logic [31:0] px);
    int        r, g, b, mx, mn, chroma, diff, mag, q, hue, sat, base;
    sector_e   sec;
    hsv_word_t w;
    r  = px[7:0];
    g  = px[15:8];
    b  = px[23:16];
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    chroma = mx - mn;
    w       = '0;
    w.value = mx[7:0];
    w.alpha = px[31:24];
    if (chroma == 0) begin
      w.missing = 1'b1;
    end else begin
      // red wins every tie, then green
      if (mx == r) sec = SecRed;
      else if (mx == g) sec = SecGreen;
      else sec = SecBlue;
      case (sec)
        SecRed: begin
          diff = g - b;
          base = 0;
        end
        SecGreen: begin
          diff = b - r;
          base = int'(HueGreenBase);
        end
        default: begin
          diff = r - g;
          base = int'(HueBlueBase);
        end
      endcase
      // round half away from zero on the magnitude
      mag = (diff < 0) ? -diff : diff;
      q   = (2 * int'(HueSector) * mag + chroma) / (2 * chroma);
      hue = base + ((diff < 0) ? -q : q);
      if (hue < 0) hue += int'(HueFullTurn);
      if (hue >= int'(HueFullTurn)) hue -= int'(HueFullTurn);
      sat = (int'(SatNumScale) * chroma + mx) / (2 * mx);
      if (sat > 255) sat = 255;
      w.hue = hue[14:0];
      w.sat = sat[7:0];
    end
    return w;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    hsv_word_t got;
    hsv_word_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) hsv_q.push_back(rgb_to_hsv(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.hue     = m_tdata_i[14:0];
        got.sat     = m_tdata_i[22:15];
        got.value   = m_tdata_i[30:23];
        got.alpha   = m_tdata_i[38:31];
        got.pad     = m_tdata_i[39];
        got.missing = m_tuser_i;
        if (hsv_q.size() == 0) begin
          $error("result word with no pixel outstanding: tdata %h tuser %b",
                 m_tdata_i, m_tuser_i);
          fails++;
        end else begin
          want = hsv_q.pop_front();
          check_field("hue", want.hue, got.hue);
          check_field("hue_missing", want.missing, got.missing);
          check_field("saturation", want.sat, got.sat);
          check_field("value", want.value, got.value);
          check_field("alpha", want.alpha, got.alpha);
          check_field("pad", want.pad, got.pad);
        end
      end
      pending_o    <= hsv_q.size();
      mismatches_o <= fails;
    end
  end

endmodule

// ===== tb/sv/tb_rgb_to_hsv_converter_core.sv =====
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter_core;

  localparam int NumPixels   = 950;
  localparam int NumPhases   = 4;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 30;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  rgb_to_hsv_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hsv_pixel_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("** rgb_to_hsv_converter_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] pack_pixel(int r, int g, int b, int a);
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic logic [31:0] random_pixel();
    int hi, lo, a;
    a  = $urandom_range(255);
    hi = $urandom_range(255);
    lo = $urandom_range(hi);
    case ($urandom_range(9))
      0: return pack_pixel(hi, hi, hi, a);
      // two components share the maximum
      1: case ($urandom_range(2))
           0: return pack_pixel(hi, hi, lo, a);
           1: return pack_pixel(hi, lo, hi, a);
           default: return pack_pixel(lo, hi, hi, a);
         endcase
      // two components share the minimum
      2: case ($urandom_range(2))
           0: return pack_pixel(lo, lo, hi, a);
           1: return pack_pixel(lo, hi, lo, a);
           default: return pack_pixel(hi, lo, lo, a);
         endcase
      // tiny values stress the rounding of both quotients
      3: return pack_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3), a);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixel(logic [31:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [31:0] directed_px[$];
    int          idle_pct[NumPhases];
    int          stall_pct[NumPhases];
    idle_pct  = '{0, 51, 0, 32};
    stall_pct = '{0, 0, 51, 32};
    directed_px = '{
      pack_pixel(0, 0, 0, 0),          // black
      pack_pixel(255, 255, 255, 255),  // white
      pack_pixel(128, 128, 128, 77),   // mid grey
      pack_pixel(255, 0, 0, 255),
      pack_pixel(0, 255, 0, 0),
      pack_pixel(0, 0, 255, 170),
      pack_pixel(255, 255, 0, 85),     // red and green tie for max
      pack_pixel(255, 0, 255, 1),      // red and blue tie, hue wraps
      pack_pixel(0, 255, 255, 254),    // green and blue tie
      pack_pixel(255, 0, 1, 128),      // small negative hue in red sector
      pack_pixel(255, 1, 0, 128),
      pack_pixel(1, 0, 0, 3),          // smallest chroma at smallest max
      pack_pixel(2, 1, 1, 12),         // saturation tie rounds up
      pack_pixel(0, 1, 255, 200),
      pack_pixel(254, 255, 253, 60),
      pack_pixel(100, 200, 50, 90),
      pack_pixel(50, 100, 200, 33),
      pack_pixel(170, 85, 255, 240)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_px[k]) send_pixel(directed_px[k]);
    drain_pipe();

    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      for (int n = 0; n < NumPixels / NumPhases; n++) send_pixel(random_pixel());
      // let the pipe empty completely before the next idling pattern
      drain_pipe();
    end

    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("** rgb_to_hsv_converter_core: PASSED **");
    end else begin
      $display("** rgb_to_hsv_converter_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rgbhsv_pkg.sv
src/rgb_to_hsv_converter_core.sv
tb/sv/hsv_pixel_checker.sv
tb/sv/tb_rgb_to_hsv_converter_core.sv
